[hw/rtl/cfe_pkg.sv]
package cfe_pkg;

  // command codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_BOOL   = 3'd0,
    MODE_I32    = 3'd1,
    MODE_I64    = 3'd2,
    MODE_STR    = 3'd3,
    MODE_BYTE   = 3'd4,
    MODE_STRUCT = 3'd5,
    MODE_STOP   = 3'd6,
    MODE_LIST   = 3'd7
  } mode_t;

  // compact type codes
  localparam logic [3:0] TYPE_STOP       = 4'd0;
  localparam logic [3:0] TYPE_BOOL_TRUE  = 4'd1;
  localparam logic [3:0] TYPE_BOOL_FALSE = 4'd2;
  localparam logic [3:0] TYPE_I32        = 4'd5;
  localparam logic [3:0] TYPE_I64        = 4'd6;
  localparam logic [3:0] TYPE_BINARY     = 4'd8;
  localparam logic [3:0] TYPE_LIST       = 4'd9;
  localparam logic [3:0] TYPE_STRUCT     = 4'd12;

  localparam logic [3:0]  LIST_LONG_NIB = 4'hF;
  localparam logic [31:0] LIST_SHORT_MAX = 32'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_IDV,
    ST_LIST,
    ST_BVAR
  } state_t;

  // source of the emitted byte
  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_VAR,
    SEL_LIST
  } sel_t;

  // varint shifter operation
  typedef enum logic [1:0] {
    VAR_HOLD,
    VAR_ID,
    VAR_BODY,
    VAR_SHIFT
  } var_op_t;

  typedef struct packed {
    logic    capture;
    logic    emit;
    sel_t    sel;
    logic    last;
    var_op_t var_op;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  hdr_short;
    logic  list_short;
    logic  var_more;
    logic  out_free;
  } sts_t;

endpackage

[hw/rtl/cfe_ctrl.sv]
module cfe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfe_pkg::sts_t sts,
  output cfe_pkg::cmd_t cmd
);
  import cfe_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   has_body;
  logic   hdr_only;

  assign has_body = (sts.mode == MODE_I32) || (sts.mode == MODE_I64) || (sts.mode == MODE_STR);
  assign hdr_only = (sts.mode == MODE_BOOL) || (sts.mode == MODE_STRUCT);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts.out_free) begin
          if ((sts.mode == MODE_BYTE) || (sts.mode == MODE_STOP)) begin
            state_nxt = ST_IDLE;
          end else if (!sts.hdr_short) begin
            state_nxt = ST_IDV;
          end else if (hdr_only) begin
            state_nxt = ST_IDLE;
          end else if (has_body) begin
            state_nxt = ST_BVAR;
          end else begin
            state_nxt = ST_LIST;
          end
        end
      end
      ST_IDV: begin
        if (sts.out_free && !sts.var_more) begin
          if (hdr_only) begin
            state_nxt = ST_IDLE;
          end else if (has_body) begin
            state_nxt = ST_BVAR;
          end else begin
            state_nxt = ST_LIST;
          end
        end
      end
      ST_LIST: begin
        if (sts.out_free) begin
          state_nxt = sts.list_short ? ST_IDLE : ST_BVAR;
        end
      end
      ST_BVAR: begin
        if (sts.out_free && !sts.var_more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.emit    = 1'b0;
    cmd.sel     = SEL_HEAD;
    cmd.last    = 1'b0;
    cmd.var_op  = VAR_HOLD;
    case (state_r)
      ST_IDLE: begin
        // no transaction is taken while reset is held
        in_ready    = rst_n;
        cmd.capture = in_valid && rst_n;
      end
      ST_HEAD: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_HEAD;
        if ((sts.mode == MODE_BYTE) || (sts.mode == MODE_STOP)) begin
          cmd.last = 1'b1;
        end else if (!sts.hdr_short) begin
          cmd.var_op = sts.out_free ? VAR_ID : VAR_HOLD;
        end else if (hdr_only) begin
          cmd.last = 1'b1;
        end else if (has_body) begin
          cmd.var_op = sts.out_free ? VAR_BODY : VAR_HOLD;
        end
      end
      ST_IDV: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_VAR;
        if (sts.var_more) begin
          cmd.var_op = sts.out_free ? VAR_SHIFT : VAR_HOLD;
        end else if (hdr_only) begin
          cmd.last = 1'b1;
        end else if (has_body) begin
          cmd.var_op = sts.out_free ? VAR_BODY : VAR_HOLD;
        end
      end
      ST_LIST: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_LIST;
        if (sts.list_short) begin
          cmd.last = 1'b1;
        end else begin
          cmd.var_op = sts.out_free ? VAR_BODY : VAR_HOLD;
        end
      end
      ST_BVAR: begin
        cmd.emit = sts.out_free;
        cmd.sel  = SEL_VAR;
        if (sts.var_more) begin
          cmd.var_op = sts.out_free ? VAR_SHIFT : VAR_HOLD;
        end else begin
          cmd.last = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/cfe_datapath.sv]
module cfe_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic         [2:0]  in_mode,
  input  logic signed  [15:0] in_field_id,
  input  logic signed  [15:0] in_last_id,
  input  logic signed  [63:0] in_value,
  input  logic         [3:0]  in_elem_type,
  input  cfe_pkg::cmd_t       cmd,
  output cfe_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic         [7:0]  out_byte,
  output logic                out_last_byte
);
  import cfe_pkg::*;

  mode_t       mode_r;
  logic        hdr_short_r;
  logic        list_short_r;
  logic [7:0]  head_r;
  logic [7:0]  list_byte_r;
  logic [16:0] id_zz_r;
  logic [63:0] body_r;
  logic [63:0] var_r;
  logic [63:0] var_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  mode_t       cap_mode;
  logic [16:0] delta;
  logic        cap_short;
  logic [3:0]  cap_type;
  logic [7:0]  cap_head;
  logic [63:0] cap_body;
  logic        cap_list_short;
  logic        var_more;
  logic [7:0]  var_byte;
  logic [7:0]  emit_byte;

  // decode of the incoming transaction
  always_comb begin
    cap_mode       = mode_t'(in_mode);
    delta          = {in_field_id[15], in_field_id} - {in_last_id[15], in_last_id};
    cap_short      = !delta[16] && (delta != 17'd0) && (delta[15:4] == 12'd0);
    cap_list_short = in_value[31:0] < LIST_SHORT_MAX;
    case (cap_mode)
      MODE_BOOL:   cap_type = in_value[0] ? TYPE_BOOL_TRUE : TYPE_BOOL_FALSE;
      MODE_I32:    cap_type = TYPE_I32;
      MODE_I64:    cap_type = TYPE_I64;
      MODE_STR:    cap_type = TYPE_BINARY;
      MODE_STRUCT: cap_type = TYPE_STRUCT;
      MODE_LIST:   cap_type = TYPE_LIST;
      default:     cap_type = TYPE_STOP;
    endcase
    case (cap_mode)
      MODE_BYTE: cap_head = in_value[7:0];
      MODE_STOP: cap_head = {4'd0, TYPE_STOP};
      default:   cap_head = cap_short ? {delta[3:0], cap_type} : {4'd0, cap_type};
    endcase
    case (cap_mode)
      MODE_I32: cap_body = {32'd0, {in_value[30:0], 1'b0} ^ {32{in_value[31]}}};
      MODE_I64: cap_body = {in_value[62:0], 1'b0} ^ {64{in_value[63]}};
      default:  cap_body = {32'd0, in_value[31:0]};
    endcase
  end

  // per-transaction registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r       <= cap_mode;
      hdr_short_r  <= cap_short;
      list_short_r <= cap_list_short;
      head_r       <= cap_head;
      list_byte_r  <= cap_list_short ? {in_value[3:0], in_elem_type}
                                     : {LIST_LONG_NIB, in_elem_type};
      id_zz_r      <= {in_field_id, 1'b0} ^ {17{in_field_id[15]}};
      body_r       <= cap_body;
    end
  end

  // varint shifter, seven bits per byte
  assign var_more = (var_r[63:7] != 57'd0);
  assign var_byte = {var_more, var_r[6:0]};

  always_comb begin
    case (cmd.var_op)
      VAR_ID:    var_nxt = {47'd0, id_zz_r};
      VAR_BODY:  var_nxt = body_r;
      VAR_SHIFT: var_nxt = {7'd0, var_r[63:7]};
      default:   var_nxt = var_r;
    endcase
  end

  always_ff @(posedge clk) begin
    var_r <= var_nxt;
  end

  // byte select
  always_comb begin
    case (cmd.sel)
      SEL_VAR:  emit_byte = var_byte;
      SEL_LIST: emit_byte = list_byte_r;
      default:  emit_byte = head_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  // status to the controller
  assign sts.mode       = mode_r;
  assign sts.hdr_short  = hdr_short_r;
  assign sts.list_short = list_short_r;
  assign sts.var_more   = var_more;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

[hw/rtl/compact_field_encoder.sv]
// compact field encoder
// turns one field-level command per input transaction into compact-protocol
// bytes, one output transaction per byte, out_last_byte set on the final one.
// input channel: in_valid/in_ready with in_mode, in_field_id, in_last_id,
// in_value and in_elem_type; a command is taken only while the block is idle.
// output channel: out_valid/out_ready with out_byte and out_last_byte, held
// in an output register.
// the first byte is loaded from the head state into the output register.
// throughput: one byte per cycle while the receiver is ready; a command that
// yields n bytes (1 to 14) holds the block until its last byte is emitted;
// all come from the single byte-wide emit path and seven-bit varint shifter.
// a stalled receiver holds the current byte in the output register and the
// sequencer waits; nothing is dropped or repeated.
// reset (rst_n low, synchronous) returns the sequencer to idle and clears
// out_valid; no command is in progress afterwards.
module compact_field_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  in_mode,
  input  logic signed [15:0] in_field_id,
  input  logic signed [15:0] in_last_id,
  input  logic signed [63:0] in_value,
  input  logic        [3:0]  in_elem_type,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [7:0]  out_byte,
  output logic               out_last_byte
);
  import cfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  cfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // byte datapath
  cfe_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_mode),
    .in_field_id   (in_field_id),
    .in_last_id    (in_last_id),
    .in_value      (in_value),
    .in_elem_type  (in_elem_type),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
